// ===== rtl/igfr_pkg.sv =====
// ----------------------------------------------------------------------------
// igfr_pkg - idle gap frame receiver shared definitions
// field widths, item codes and register map for the receiver and its csr block
// ----------------------------------------------------------------------------
`default_nettype none

package igfr_pkg;

   // item field widths
   localparam int unsigned OP_W     = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BSIZE_W  = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned NEED_W   = 7;

   // idle tick counter saturates at its all-ones value
   localparam int unsigned          IDLE_W   = 17;
   localparam logic [IDLE_W-1:0]    IDLE_MAX = 17'h1FFFF;

   // gap register
   localparam int unsigned          GAP_W     = 16;
   localparam logic [GAP_W-1:0]     GAP_RESET = 16'd5;

   // csr port
   localparam int unsigned          CSR_ADDR_W = 3;
   localparam int unsigned          CSR_DATA_W = 32;
   localparam logic                 REG_GAP_TICKS = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_TICK = 2'd0,
      OP_BYTE = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_DATA  = 2'd1,
      STATUS_SMALL = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/idle_gap_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// idle_gap_frame_receiver - serial byte message assembler
// gathers received bytes into a message closed by line silence and streams
// it out on request
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  req      | in        | tvalid / tready    | tuser op, tdata rx_byte,buf_size
//  rsp      | out       | tvalid / tready    | tuser status, tdata data,need,
//           |           |                    | tlast last
//  csr      | in/out    | psel/penable/pready| gap_ticks at address 0
//
//  a tick or a received byte is taken while idle and the block stays ready
//  for the next item
//  a read request passes the check state, then either gives one result or
//  goes through the fetch state and the send state, one item per stored byte;
//  the fetch state comes from the single registered read port of the memory
//  a stalled rsp side holds the sequencer in place; nothing is dropped
//  reset is synchronous, clears length, idle count and the sequencer and sets
//  the gap to 5; the message memory is not cleared
//
`default_nettype none

module idle_gap_frame_receiver #(
   parameter int unsigned MAX_LEN = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [23:0]                       req_tdata,   // rx_byte[7:0], buf_size[23:8]
   input  wire logic [igfr_pkg::OP_W-1:0]         req_tuser,   // op[1:0]
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [15:0]                       rsp_tdata,   // data_byte[7:0], needed_length[14:8], zero[15]
   output logic      [igfr_pkg::STATUS_W-1:0]     rsp_tuser,   // status[1:0]
   output logic                                   rsp_tlast,
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [igfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [igfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [igfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import igfr_pkg::*;

   // length counts 0..MAX_LEN, address indexes 0..MAX_LEN-1
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_SEND
   } state_type;

   // unpack the input item
   op_type              req_op;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic [BSIZE_W-1:0]  req_buf_size;

   assign req_op       = op_type'(req_tuser);
   assign req_rx_byte  = req_tdata[7:0];
   assign req_buf_size = req_tdata[23:8];

   logic [GAP_W-1:0] gap_ticks;

   igfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gap_ticks   (gap_ticks)
   );

   // sequencer and control state
   state_type           state_ff,    state_in;
   logic [IDLE_W-1:0]   idle_ff,     idle_in;
   logic [LEN_W-1:0]    len_ff,      len_in;
   logic [LEN_W-1:0]    idx_ff,      idx_in;
   logic [BSIZE_W-1:0]  bsize_ff,    bsize_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_data_ff,  rsp_data_in;
   logic [NEED_W-1:0]   rsp_need_ff,  rsp_need_in;
   logic                rsp_last_ff,  rsp_last_in;

   // message memory, one write and one registered read port
   logic [BYTE_W-1:0]   msg_store_ff [MAX_LEN];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   logic                gap_passed;
   logic                out_free;
   logic [LEN_W-1:0]    len_base;
   logic [LEN_W-1:0]    idx_next;
   logic                is_last;

   // silence on the line is longer than the gap setting
   assign gap_passed = idle_ff > {{(IDLE_W-GAP_W){1'b0}}, gap_ticks};
   // output slot empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // a byte after the gap starts a new message
   assign len_base   = gap_passed ? '0 : len_ff;
   assign idx_next   = idx_ff + LEN_W'(1);
   assign is_last    = (idx_next == len_ff);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      idle_in       = idle_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      bsize_in      = bsize_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_need_in   = rsp_need_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = len_base[ADDR_W-1:0];
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_TICK: begin
                     // saturating idle count
                     if (idle_ff != IDLE_MAX) begin
                        idle_in = idle_ff + IDLE_W'(1);
                     end
                  end
                  OP_BYTE: begin
                     // store while room remains, always restart silence
                     len_in = len_base;
                     if (len_base < LEN_MAX) begin
                        wr_en  = 1'b1;
                        len_in = len_base + LEN_W'(1);
                     end
                     idle_in = '0;
                  end
                  OP_READ: begin
                     bsize_in = req_buf_size;
                     state_in = S_CHECK;
                  end
                  default: begin
                     // unused op code, item taken and ignored
                  end
               endcase
            end
         end

         S_CHECK: begin
            if (out_free) begin
               if (!gap_passed || (len_ff == '0)) begin
                  // nothing ready
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NONE;
                  rsp_data_in   = '0;
                  rsp_need_in   = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else if (bsize_ff < {{(BSIZE_W-LEN_W){1'b0}}, len_ff}) begin
                  // caller buffer too small, message kept
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_SMALL;
                  rsp_data_in   = '0;
                  rsp_need_in   = NEED_W'(len_ff);
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = S_FETCH;
               end
            end
         end

         S_FETCH: begin
            // prime the read pipe with the first byte
            rd_en    = 1'b1;
            rd_addr  = idx_ff[ADDR_W-1:0];
            state_in = S_SEND;
         end

         S_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DATA;
               rsp_data_in   = rd_data_ff;
               rsp_need_in   = '0;
               rsp_last_in   = is_last;
               // fetch the following byte while this one leaves
               rd_en         = 1'b1;
               rd_addr       = idx_next[ADDR_W-1:0];
               idx_in        = idx_next;
               if (is_last) begin
                  len_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idle_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idle_ff      <= idle_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      bsize_ff      <= bsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_need_ff   <= rsp_need_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_store_ff[wr_addr] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= msg_store_ff[rd_addr];
      end
   end

   // pack the result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_need_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/igfr_csr.sv =====
// ----------------------------------------------------------------------------
// igfr_csr - configuration register block
// apb-style access to the gap register, write on the access phase
// ----------------------------------------------------------------------------
`default_nettype none

module igfr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [igfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [igfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [igfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output logic      [igfr_pkg::GAP_W-1:0]        gap_ticks
);
   import igfr_pkg::*;

   logic [GAP_W-1:0] gap_ticks_ff;
   logic [GAP_W-1:0] gap_ticks_in;
   logic             reg_index;
   logic             wr_fire;

   // register index is the word address
   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      gap_ticks_in = gap_ticks_ff;
      if (wr_fire && (reg_index == REG_GAP_TICKS)) begin
         gap_ticks_in = csr_pwdata[GAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= GAP_RESET;
      end else begin
         gap_ticks_ff <= gap_ticks_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_GAP_TICKS) begin
         csr_prdata = {{(CSR_DATA_W-GAP_W){1'b0}}, gap_ticks_ff};
      end
   end

   assign gap_ticks = gap_ticks_ff;

endmodule

`default_nettype wire
